// ===== rtl/audio_echo_delay_mix_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the echo delay mix RTL.
// ----------------------------------------------------------------------------
`ifndef AUDIO_ECHO_DELAY_MIX_ASSERT_SVH
`define AUDIO_ECHO_DELAY_MIX_ASSERT_SVH

`ifndef ASSERT_OFF
`define AEDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AEDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AEDM_ASSERT(lbl, prop, msg)
`define AEDM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/aedm_pkg.sv =====
// ----------------------------------------------------------------------------
// aedm_pkg
// Shared widths, register codes and sequencer states of the echo delay mix.
// ----------------------------------------------------------------------------
`default_nettype none

package aedm_pkg;

  localparam int MAX_DELAY_DEF = 8192;
  localparam int SAMPLE_W      = 16;
  localparam int DELAY_W       = 14;
  localparam int DIVISOR_W     = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int DIV_STEPS     = SAMPLE_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam logic [DELAY_W-1:0]   DELAY_RST   = 14'd8000;
  localparam logic [DIVISOR_W-1:0] DIVISOR_RST = 16'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ECHO_DELAY   = 1'b0,
    REG_ECHO_DIVISOR = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_WB
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/aedm_div.sv =====
// ----------------------------------------------------------------------------
// aedm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aedm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [aedm_pkg::SAMPLE_W-1:0]  dividend,
  input  logic [aedm_pkg::DIVISOR_W-1:0] divisor,
  output logic                           busy,
  output logic                           done,
  output logic [aedm_pkg::SAMPLE_W-1:0]  quotient
);
  import aedm_pkg::*;

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [SAMPLE_W-1:0]  quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  assign shifted = {rem, quo[SAMPLE_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (running) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo <= {quo[SAMPLE_W-2:0], fits};
    end
  end

  assign busy     = running;
  assign quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/audio_echo_delay_mix.sv =====
// ----------------------------------------------------------------------------
// audio_echo_delay_mix
// Feedforward comb filter: adds a scaled, delayed copy of the input stream.
// ----------------------------------------------------------------------------
// Each accepted item gives one result. The delay line is read in the accept
// cycle. A restoring divider then works out the scaled sample, one quotient
// bit per cycle. The divider then reports done and the sequencer moves to
// write-back. The write-back state stores the scaled sample and loads the
// output register. No new item is accepted while an item is in the divider
// or in write-back. Write-back waits while an earlier result has not yet been
// taken. The input side is ready again as soon as the write-back is done,
// even while that result still waits to be taken. The delay line holds
// MAX_DELAY entries and needs no clearing after reset.
`default_nettype none

`include "audio_echo_delay_mix_assert.svh"

module audio_echo_delay_mix #(
  parameter int MAX_DELAY = aedm_pkg::MAX_DELAY_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wen,
  input  logic [aedm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [aedm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   sample_valid,
  output logic                                   sample_ready,
  input  logic signed [aedm_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic                                   flush,
  input  logic                                   restart,
  output logic                                   result_valid,
  input  logic                                   result_ready,
  output logic signed [aedm_pkg::SAMPLE_W-1:0]   sample_out
);
  import aedm_pkg::*;

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int EW = $clog2(MAX_DELAY + 1);
  localparam int CW = (EW > DELAY_W) ? EW : DELAY_W;

  state_t state, state_next;

  logic [DELAY_W-1:0]   echo_delay;
  logic [DIVISOR_W-1:0] echo_divisor;
  logic [AW-1:0]        write_index;
  logic [EW-1:0]        fill_count;

  logic [SAMPLE_W-1:0]  store [MAX_DELAY];
  logic [SAMPLE_W-1:0]  rd_data;
  logic [AW-1:0]        slot_reg;
  logic                 full_reg;
  logic                 neg_reg;
  logic [SAMPLE_W-1:0]  x_reg;

  logic                 accept;
  logic                 load_out;
  logic [EW-1:0]        eff_d;
  logic [AW-1:0]        idx0;
  logic [EW-1:0]        fill0;
  logic [AW-1:0]        slot;
  logic [EW-1:0]        slot_inc;
  logic                 full;
  logic [AW-1:0]        write_index_next;
  logic [EW-1:0]        fill_count_next;
  logic [SAMPLE_W-1:0]  x_in;
  logic [SAMPLE_W-1:0]  mag;
  logic [DIVISOR_W-1:0] dvs_eff;
  logic [SAMPLE_W-1:0]  q_signed;
  logic [SAMPLE_W-1:0]  sum;

  logic                 div_busy;
  logic                 div_done;
  logic [SAMPLE_W-1:0]  div_q;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_delay   <= DELAY_RST;
      echo_divisor <= DIVISOR_RST;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ECHO_DELAY:   echo_delay   <= cfg_data[DELAY_W-1:0];
        REG_ECHO_DIVISOR: echo_divisor <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (echo_delay == '0) begin
      eff_d = EW'(1);
    end else if (CW'(echo_delay) > CW'(MAX_DELAY)) begin
      eff_d = EW'(MAX_DELAY);
    end else begin
      eff_d = EW'(echo_delay);
    end
  end

  // Slot and fill bookkeeping for the item at the input
  always_comb begin
    idx0             = restart ? '0 : write_index;
    fill0            = restart ? '0 : fill_count;
    slot             = (EW'(idx0) >= eff_d) ? '0 : idx0;
    full             = fill0 >= eff_d;
    slot_inc         = EW'(slot) + 1'b1;
    write_index_next = (slot_inc == eff_d) ? '0 : slot_inc[AW-1:0];
    fill_count_next  = full ? eff_d : fill0 + 1'b1;
    x_in             = flush ? '0 : sample_in;
    mag              = x_in[SAMPLE_W-1] ? (~x_in + 1'b1) : x_in;
    dvs_eff          = (echo_divisor == '0) ? DIVISOR_W'(1) : echo_divisor;
  end

  assign accept   = sample_valid && sample_ready;
  assign load_out = (state == ST_WB) && (!result_valid || result_ready);
  assign q_signed = neg_reg ? (~div_q + 1'b1) : div_q;
  assign sum      = x_reg + (full_reg ? rd_data : '0);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = ST_WB;
      end
      ST_WB: begin
        if (!result_valid || result_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index  <= '0;
      fill_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        write_index <= write_index_next;
        fill_count  <= fill_count_next;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold the item while the divider runs, and load the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      slot_reg <= slot;
      full_reg <= full;
      neg_reg  <= x_in[SAMPLE_W-1];
      x_reg    <= x_in;
    end
    if (load_out) begin
      sample_out <= sum;
    end
  end

  // Delay line
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= store[slot];
    end
    if (state == ST_WB) begin
      store[slot_reg] <= q_signed;
    end
  end

  aedm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (mag),
    .divisor  (dvs_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  `AEDM_ASSERT(a_accept_starts_div, accept |=> (div_busy && state == ST_DIV), "divider not started")
  `AEDM_ASSERT(a_done_only_in_div, div_done |-> (state == ST_DIV), "divider done outside DIV")
  `AEDM_ASSERT(a_busy_only_in_div, div_busy |-> (state == ST_DIV && !result_valid || state == ST_DIV), "divider busy outside DIV")
  `AEDM_ASSERT(a_wb_loads_out, load_out |=> (result_valid && state == ST_IDLE), "result not loaded")
  `AEDM_ASSERT_ALWAYS(a_ready_idle, (sample_ready && !rst) |-> !div_busy, "ready while dividing")

endmodule

`default_nettype wire

// ===== tb/echo_mix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_mix_checker
// Watches the register port and both item channels of the echo delay mix,
// keeps its own copy of the delay line, and compares every result it sees.
// ----------------------------------------------------------------------------

module echo_mix_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_wen,
  input  logic [aedm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [aedm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   sample_valid,
  input  logic                                   sample_ready,
  input  logic signed [aedm_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic                                   flush,
  input  logic                                   restart,
  input  logic                                   result_valid,
  input  logic                                   result_ready,
  input  logic signed [aedm_pkg::SAMPLE_W-1:0]   sample_out,
  output int                                     fail_count,
  output int                                     pending
);
  import aedm_pkg::*;

  logic [DELAY_W-1:0]          delay_reg;
  logic [DIVISOR_W-1:0]        divisor_reg;
  logic [SAMPLE_W-1:0]         echo_line [MAX_DELAY_DEF];
  int                          tap_index;
  int                          fill_depth;
  int                          errors;
  logic signed [SAMPLE_W-1:0]  expected_mix [$];

  function automatic logic signed [SAMPLE_W-1:0] mix_echo(
    input logic signed [SAMPLE_W-1:0] smp,
    input logic                       fl,
    input logic                       rs
  );
    int span;
    int dv;
    int x;
    int e;
    int slot;
    span = int'(delay_reg);
    if (span == 0) span = 1;
    if (span > MAX_DELAY_DEF) span = MAX_DELAY_DEF;
    dv = (divisor_reg == '0) ? 1 : int'(divisor_reg);
    x = fl ? 0 : int'(smp);
    e = 0;
    if (rs) begin
      tap_index = 0;
      fill_depth = 0;
    end
    if (tap_index >= span) tap_index = 0;
    slot = tap_index;
    if (fill_depth >= span) begin
      fill_depth = span;
      e = int'($signed(echo_line[slot]));
    end else begin
      fill_depth++;
    end
    echo_line[slot] = 16'(x / dv);
    tap_index = (slot + 1 == span) ? 0 : slot + 1;
    return 16'(x + e);
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      delay_reg = DELAY_RST;
      divisor_reg = DIVISOR_RST;
      tap_index = 0;
      fill_depth = 0;
      errors = 0;
      expected_mix.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_mix.size() == 0) begin
          errors++;
          $error("sample_out: expected no item, got %0d", sample_out);
        end else begin
          want = expected_mix.pop_front();
          if (sample_out !== want) begin
            errors++;
            $error("sample_out: expected %0d, got %0d", want, sample_out);
          end
        end
      end
      if (sample_valid && sample_ready)
        expected_mix.push_back(mix_echo(sample_in, flush, restart));
      if (cfg_wen) begin
        if (cfg_index == REG_ECHO_DELAY) delay_reg = cfg_data[DELAY_W-1:0];
        else if (cfg_index == REG_ECHO_DIVISOR) divisor_reg = cfg_data[DIVISOR_W-1:0];
      end
    end
    fail_count <= errors;
    pending <= expected_mix.size();
  end

endmodule

// ===== tb/tb_audio_echo_delay_mix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_echo_delay_mix
// Drives directed and random sample streams into the echo delay mix under
// several delay and divisor settings and idling patterns; the checker
// beside the block predicts and compares each result.
// ----------------------------------------------------------------------------

module tb_audio_echo_delay_mix;
  import aedm_pkg::*;

  localparam int DRAIN_CYCLES = 24;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = REG_ECHO_DELAY;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        sample_valid = 1'b0;
  logic                        sample_ready;
  logic signed [SAMPLE_W-1:0]  sample_in = '0;
  logic                        flush = 1'b0;
  logic                        restart = 1'b0;
  logic                        result_valid;
  logic                        result_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample_out;
  int                          fail_count;
  int                          pending;

  int                          send_idle_pct = 0;
  int                          stall_pct = 0;
  int                          items_sent = 0;
  int                          reg_writes = 0;
  int                          line_len = int'(DELAY_RST);
  bit                          need_restart = 1'b0;

  audio_echo_delay_mix u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_in    (sample_in),
    .flush        (flush),
    .restart      (restart),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample_out   (sample_out)
  );

  echo_mix_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_in    (sample_in),
    .flush        (flush),
    .restart      (restart),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample_out   (sample_out),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_item(input logic signed [SAMPLE_W-1:0] smp, input logic fl,
                           input logic rs);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 30);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_in <= smp;
    flush <= fl;
    restart <= rs | need_restart;
    need_restart = 1'b0;
    do @(posedge clk); while (!sample_ready);
    items_sent++;
  endtask

  // hold the sender until every result is back, then let the block go quiet
  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    int span;
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    reg_writes++;
    if (idx == REG_ECHO_DELAY) begin
      span = int'(val[DELAY_W-1:0]);
      if (span == 0) span = 1;
      if (span > MAX_DELAY_DEF) span = MAX_DELAY_DEF;
      // a longer line would reach slots never written: start a new stream
      if (span > line_len) need_restart = 1'b1;
      line_len = span;
    end
  endtask

  task automatic feed(input int n, input int restart_pct);
    for (int i = 0; i < n; i++) begin
      send_item(16'($urandom), $urandom_range(99) < 10, $urandom_range(99) < restart_pct);
      if ($urandom_range(199) == 0) settle();
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] dval;
    logic [CFG_DATA_W-1:0] vval;
    int target;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // wraparound at both extremes, flush with a live sample, restart mid-stream
    write_reg(REG_ECHO_DELAY, 16'd3);
    write_reg(REG_ECHO_DIVISOR, 16'd1);
    send_item(16'sh7FFF, 1'b0, 1'b1);
    send_item(16'sh8000, 1'b0, 1'b0);
    send_item(16'sh7FFF, 1'b0, 1'b0);
    send_item(16'sh7FFF, 1'b0, 1'b0);
    send_item(16'sh8000, 1'b0, 1'b0);
    send_item(-16'sd1, 1'b1, 1'b0);
    send_item(-16'sd1, 1'b1, 1'b0);
    send_item(-16'sd1, 1'b1, 1'b0);
    send_item(16'sd12345, 1'b0, 1'b1);
    settle();
    write_reg(REG_ECHO_DELAY, 16'd0);
    write_reg(REG_ECHO_DIVISOR, 16'd0);
    send_item(-16'sd7, 1'b0, 1'b0);
    send_item(16'sd5, 1'b0, 1'b0);
    settle();
    write_reg(REG_ECHO_DIVISOR, 16'd3);
    send_item(-16'sd7, 1'b0, 1'b0);
    send_item(-16'sd7, 1'b0, 1'b0);
    settle();
    write_reg(REG_ECHO_DIVISOR, 16'hFFFF);
    send_item(16'sh8000, 1'b0, 1'b0);
    send_item(16'sh7FFF, 1'b0, 1'b0);
    send_item(16'sh7FFF, 1'b0, 1'b0);
    settle();
    write_reg(REG_ECHO_DELAY, 16'd6);
    write_reg(REG_ECHO_DIVISOR, 16'd2);
    send_item(16'sd100, 1'b0, 1'b0);
    send_item(16'sd200, 1'b0, 1'b0);
    send_item(-16'sd300, 1'b0, 1'b0);
    send_item(16'sd400, 1'b0, 1'b0);
    send_item(-16'sd501, 1'b0, 1'b0);
    settle();
    // shorten the line mid-stream: index and fill fold back
    write_reg(REG_ECHO_DELAY, 16'd2);
    send_item(16'sd7, 1'b0, 1'b0);
    send_item(16'sd8, 1'b0, 1'b0);
    send_item(16'sd9, 1'b0, 1'b0);

    // full-length line: delay above the store clamps to its depth
    settle();
    write_reg(REG_ECHO_DELAY, 16'h3FFF);
    write_reg(REG_ECHO_DIVISOR, 16'($urandom_range(1, 8)));
    feed(40, 0);
    settle();
    write_reg(REG_ECHO_DELAY, 16'(MAX_DELAY_DEF));
    feed(10, 0);
    settle();
    write_reg(REG_ECHO_DELAY, 16'd5);
    feed(10, 0);

    for (int mode = 0; mode < 4; mode++) begin
      settle();
      case (mode)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      target = items_sent + 150;
      while (items_sent < target) begin
        settle();
        case ($urandom_range(9))
          0: dval = {2'($urandom_range(3)), 14'd0};
          1: dval = 16'($urandom);
          default: dval = {2'($urandom_range(3)), 14'($urandom_range(1, 24))};
        endcase
        case ($urandom_range(7))
          0: vval = 16'd0;
          1: vval = 16'd1;
          2: vval = 16'hFFFF;
          3: vval = 16'($urandom);
          default: vval = 16'($urandom_range(2, 9));
        endcase
        write_reg(REG_ECHO_DELAY, dval);
        write_reg(REG_ECHO_DIVISOR, vval);
        if ($urandom_range(1) == 1) need_restart = 1'b1;
        feed($urandom_range(12, 24), 3);
        // drain the echo tail
        if (line_len <= 24) repeat (line_len) send_item(16'($urandom), 1'b1, 1'b0);
      end
    end

    settle();
    $display("Run covered %0d items and %0d register writes, delays from one sample",
             items_sent, reg_writes);
    $display("to the full line, under no idling, sender, receiver and mixed stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(12 * 3_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
